// ===== src/mhp_pkg.sv =====
// types and constants shared by the mac header parser
// no dependencies
package mhp_pkg;

  // addressing mode codes from the frame control word
  localparam logic [1:0] ADDR_NONE     = 2'd0;
  localparam logic [1:0] ADDR_RESERVED = 2'd1;
  localparam logic [1:0] ADDR_SHORT    = 2'd2;
  localparam logic [1:0] ADDR_EXT      = 2'd3;

  localparam logic [3:0] SHORT_LEN  = 4'd2;
  localparam logic [3:0] EXT_LEN    = 4'd8;
  localparam logic [4:0] PAN_LEN    = 5'd2;
  localparam logic [4:0] DST_PAN_AT = 5'd3;
  localparam logic [4:0] DST_ADR_AT = 5'd5;
  localparam logic [4:0] SEQ_AT     = 5'd2;
  localparam logic [4:0] POS_MAX    = 5'd31;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_SHORT    = 2'd1,
    STATUS_RESERVED = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    status_t     status;
    logic [2:0]  frame_type;
    logic        ack_request;
    logic        pan_id_compression;
    logic [1:0]  dst_addr_mode;
    logic [1:0]  src_addr_mode;
    logic [7:0]  sequence_number;
    logic [15:0] dst_pan_id;
    logic [63:0] dst_address;
    logic [15:0] src_pan_id;
    logic [63:0] src_address;
    logic [4:0]  header_length;
  } out_word_t;

  // header layout derived from the frame control word
  typedef struct packed {
    logic [1:0] dm;
    logic [1:0] sm;
    logic       pc;
    logic [3:0] dl;
    logic [3:0] sl;
    logic [4:0] s_at;
    logic [4:0] saddr_at;
    logic [4:0] hlen;
  } layout_t;

endpackage

// ===== src/mhp_layout.sv =====
// header layout decode: field offsets and header length from frame control
// depends on mhp_pkg
module mhp_layout
  import mhp_pkg::*;
(
  input  logic [15:0] frame_control,
  output layout_t     layout
);

  function automatic logic [3:0] mode_len(input logic [1:0] mode);
    case (mode)
      ADDR_SHORT: mode_len = SHORT_LEN;
      ADDR_EXT:   mode_len = EXT_LEN;
      default:    mode_len = 4'd0;
    endcase
  endfunction

  always_comb begin
    layout.dm = frame_control[11:10];
    layout.sm = frame_control[15:14];
    layout.pc = frame_control[6];
    layout.dl = mode_len(layout.dm);
    layout.sl = mode_len(layout.sm);
    layout.s_at = (layout.dm != ADDR_NONE) ? DST_ADR_AT + {1'b0, layout.dl} : DST_PAN_AT;
    layout.saddr_at = (layout.sm != ADDR_NONE && !layout.pc) ? layout.s_at + PAN_LEN
                                                              : layout.s_at;
    layout.hlen = (layout.sm != ADDR_NONE) ? layout.saddr_at + {1'b0, layout.sl}
                                           : layout.s_at;
  end

endmodule

// ===== src/mac_header_parser.sv =====
// top level of the mac header parser: input register, frame state, result register
// depends on mhp_pkg and mhp_layout
//
// usage
//   frame_* carries one frame byte per word, last_byte set on the final byte
//   hdr_* carries one result word per frame: status, decoded frame control,
//   sequence number, pans, addresses and header length
//   a result comes when the header completes, at the third byte on a reserved
//   addressing mode, or on the last byte when the frame is too short; later
//   bytes of the frame are dropped until last_byte, which starts a new frame
// timing
//   one byte accepted per clock while frame_stall is low; a result appears once the byte
//   that completes it has passed the input register and then the result register
//   the single-byte recurrence on the frame state sets the byte rate
// reset
//   rst (synchronous) empties both registers and clears the frame state,
//   so the next byte is taken as the first byte of a frame
// backpressure
//   while a result waits under hdr_stall, a byte already in the input
//   register holds and frame_stall rises; otherwise bytes keep flowing
module mac_header_parser
  import mhp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      frame_valid,
  output logic      frame_stall,
  input  in_word_t  frame_data,
  output logic      hdr_valid,
  input  logic      hdr_stall,
  output out_word_t hdr_data
);

  // input register
  logic     r_valid;
  in_word_t r_word;

  // frame state
  logic [4:0]  byte_position, byte_position_next;
  logic [15:0] frame_control, frame_control_next;
  logic [7:0]  seq_store, seq_store_next;
  logic [15:0] dst_pan_store, dst_pan_store_next;
  logic [63:0] dst_addr_store, dst_addr_store_next;
  logic [15:0] src_pan_store, src_pan_store_next;
  logic [63:0] src_addr_store, src_addr_store_next;
  logic        result_given, result_given_next;

  logic      advance, proc, emit;
  status_t   status;
  layout_t   lay;
  out_word_t result;
  logic [7:0] b;
  logic [4:0] p;
  logic [4:0] off_dpan, off_daddr, off_span, off_saddr;
  logic [63:0] b64;

  // result register frees when empty or being taken
  assign advance     = !(hdr_valid && hdr_stall);
  assign frame_stall = r_valid && !advance;
  assign proc        = r_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (!frame_stall) begin
      r_valid <= frame_valid;
    end
    if (!frame_stall && frame_valid) begin
      r_word <= frame_data;
    end
  end

  assign b   = r_word.byte_value;
  assign p   = byte_position;
  assign b64 = {56'd0, b};

  // frame control is taken with this byte before the layout is judged
  always_comb begin
    frame_control_next = frame_control;
    if (p == 5'd0) frame_control_next = {frame_control[15:8], b};
    else if (p == 5'd1) frame_control_next = {b, frame_control[7:0]};
  end

  mhp_layout u_layout (
    .frame_control (frame_control_next),
    .layout        (lay)
  );

  assign off_dpan  = p - DST_PAN_AT;
  assign off_daddr = p - DST_ADR_AT;
  assign off_span  = p - lay.s_at;
  assign off_saddr = p - lay.saddr_at;

  always_comb begin
    seq_store_next      = (p == SEQ_AT) ? b : seq_store;
    dst_pan_store_next  = dst_pan_store;
    dst_addr_store_next = dst_addr_store;
    src_pan_store_next  = src_pan_store;
    src_addr_store_next = src_addr_store;

    // little-endian byte lanes of the pan and address fields
    if (p >= DST_PAN_AT) begin
      if (lay.dm != ADDR_NONE && p < DST_ADR_AT) begin
        dst_pan_store_next = dst_pan_store | ({8'd0, b} << {off_dpan[0], 3'b000});
      end else if (lay.dm != ADDR_NONE && p >= DST_ADR_AT &&
                   p < DST_ADR_AT + {1'b0, lay.dl}) begin
        dst_addr_store_next = dst_addr_store | (b64 << {off_daddr[2:0], 3'b000});
      end else if (lay.sm != ADDR_NONE && !lay.pc && p >= lay.s_at &&
                   p < lay.saddr_at) begin
        src_pan_store_next = src_pan_store | ({8'd0, b} << {off_span[0], 3'b000});
      end else if (lay.sm != ADDR_NONE && p >= lay.saddr_at &&
                   p < lay.saddr_at + {1'b0, lay.sl}) begin
        src_addr_store_next = src_addr_store | (b64 << {off_saddr[2:0], 3'b000});
      end
    end

    // result decision
    emit   = 1'b0;
    status = STATUS_OK;
    if (p == SEQ_AT && (lay.dm == ADDR_RESERVED || lay.sm == ADDR_RESERVED)) begin
      emit   = 1'b1;
      status = STATUS_RESERVED;
    end else if (p >= SEQ_AT && ({1'b0, p} + 6'd1) == {1'b0, lay.hlen}) begin
      emit   = 1'b1;
      status = STATUS_OK;
    end else if (r_word.last_byte) begin
      emit   = 1'b1;
      status = STATUS_SHORT;
    end

    // dropping the tail of a frame after its result
    if (result_given) emit = 1'b0;

    byte_position_next = byte_position;
    result_given_next  = result_given;
    if (!result_given && !emit && p < POS_MAX) byte_position_next = p + 5'd1;
    if (!result_given && emit) result_given_next = 1'b1;

    // result word, zero apart from status on any error
    result = '0;
    result.status = status;
    if (status == STATUS_OK) begin
      result.frame_type         = frame_control_next[2:0];
      result.ack_request        = frame_control_next[5];
      result.pan_id_compression = lay.pc;
      result.dst_addr_mode      = lay.dm;
      result.src_addr_mode      = lay.sm;
      result.sequence_number    = seq_store_next;
      result.dst_pan_id         = dst_pan_store_next;
      result.dst_address        = dst_addr_store_next;
      if (lay.sm != ADDR_NONE) begin
        result.src_pan_id = lay.pc ? dst_pan_store_next : src_pan_store_next;
      end
      result.src_address        = src_addr_store_next;
      result.header_length      = lay.hlen;
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (rst || (proc && r_word.last_byte)) begin
      byte_position  <= '0;
      frame_control  <= '0;
      seq_store      <= '0;
      dst_pan_store  <= '0;
      dst_addr_store <= '0;
      src_pan_store  <= '0;
      src_addr_store <= '0;
      result_given   <= 1'b0;
    end else if (proc && !result_given) begin
      byte_position  <= byte_position_next;
      frame_control  <= frame_control_next;
      seq_store      <= seq_store_next;
      dst_pan_store  <= dst_pan_store_next;
      dst_addr_store <= dst_addr_store_next;
      src_pan_store  <= src_pan_store_next;
      src_addr_store <= src_addr_store_next;
      result_given   <= result_given_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_valid <= 1'b0;
    end else if (advance) begin
      hdr_valid <= proc && emit;
    end
    if (advance && proc && emit) begin
      hdr_data <= result;
    end
  end

endmodule
